FILE: rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared codes, constants and the cell command type of the list store.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int DATA_W = 32;

	typedef logic [1:0] action_t;
	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_DELETE = 2'd1;
	localparam action_t ACT_READ   = 2'd2;
	localparam action_t ACT_SWAP   = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_RANGE = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic signed [DATA_W-1:0] OUT_OF_RANGE_VALUE = -32'sd32000;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic delete;
		logic swap;
	} cell_cmd_t;

endpackage

FILE: rtl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One storage cell of the list chain; holds the entry at a fixed slot.
// ----------------------------------------------------------------------------
module pls_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  pls_pkg::cell_cmd_t                cmd,
	input  logic [IW-1:0]                     index_a,
	input  logic [IW-1:0]                     index_b,
	input  logic signed [pls_pkg::DATA_W-1:0] value,
	input  logic signed [pls_pkg::DATA_W-1:0] left_data,
	input  logic signed [pls_pkg::DATA_W-1:0] right_data,
	input  logic signed [pls_pkg::DATA_W-1:0] swap_a_data,
	input  logic signed [pls_pkg::DATA_W-1:0] swap_b_data,
	output logic signed [pls_pkg::DATA_W-1:0] sel_a_data,
	output logic signed [pls_pkg::DATA_W-1:0] sel_b_data,
	output logic signed [pls_pkg::DATA_W-1:0] data
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [pls_pkg::DATA_W-1:0] data_q;
	logic                              hit_a;
	logic                              hit_b;

	assign hit_a = (index_a == MY_IDX);
	assign hit_b = (index_b == MY_IDX);

	assign sel_a_data = hit_a ? data_q : '0;
	assign sel_b_data = hit_b ? data_q : '0;
	assign data       = data_q;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			// The new value lands here; everything above moves up by one.
			if (hit_a) begin
				data_q <= value;
			end else if (MY_IDX > index_a) begin
				data_q <= left_data;
			end
		end else if (cmd.delete) begin
			if (MY_IDX >= index_a) begin
				data_q <= right_data;
			end
		end else if (cmd.swap) begin
			if (hit_a) begin
				data_q <= swap_b_data;
			end else if (hit_b) begin
				data_q <= swap_a_data;
			end
		end
	end

endmodule

FILE: rtl/positional_list_store_core.sv
// ----------------------------------------------------------------------------
// positional_list_store_core
// Ordered list of signed 32-bit values addressed by one-based position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item: an action (insert,
//   delete, read or swap), two positions and a value. The output channel
//   (out_valid/out_stall) returns exactly one result item per input item:
//   the value read, a status code and the list length after the action.
//   The list lives in a chain of CAPACITY cells; inserts and deletes shift
//   the cells at and above the addressed slot toward their neighbors.
//   Each item passes accept, fetch of the addressed cells into registers,
//   and apply, which updates the cells and loads the output register. A
//   new item is taken only once the last one has left apply, since the
//   fetch and apply steps share the cell chain.
//   A new item is accepted while a finished result still waits in the
//   output register; if the receiver keeps stalling, the next item holds in
//   its apply step until the register frees up.
//   Reset empties the list and clears the handshake state; no clearing
//   pass is needed since entries are only read after they were written.
// ----------------------------------------------------------------------------
module positional_list_store_core #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        action,
	input  logic [7:0]                        position_a,
	input  logic [7:0]                        position_b,
	input  logic signed [pls_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [pls_pkg::DATA_W-1:0] read_value,
	output logic [1:0]                        status,
	output logic [6:0]                        list_length
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 8) ? CW : 8;
	localparam int LW = (CW > 7) ? CW : 7;
	localparam int DW = pls_pkg::DATA_W;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_APPLY = 3'b100
	} state_t;

	state_t state_q;

	pls_pkg::action_t  action_q;
	logic [7:0]        pa_q;
	logic [7:0]        pb_q;
	logic signed [DW-1:0] value_q;
	logic [CW-1:0]     count_q;
	logic signed [DW-1:0] read_a_q;
	logic signed [DW-1:0] read_b_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] read_value_q;
	pls_pkg::status_t     status_q;
	logic [6:0]           list_length_q;

	logic [PW-1:0] pa_ext;
	logic [PW-1:0] pb_ext;
	logic [PW-1:0] count_ext;
	logic [PW-1:0] pa_m1;
	logic [PW-1:0] pb_m1;
	logic          valid_a;
	logic          valid_b;
	logic          full;
	logic [IW-1:0] idx_a;
	logic [IW-1:0] idx_b;
	logic [IW-1:0] slot;
	logic [IW-1:0] index_a;
	logic          fire;

	pls_pkg::cell_cmd_t   cmd;
	logic signed [DW-1:0] cell_sel_a [CAPACITY];
	logic signed [DW-1:0] cell_sel_b [CAPACITY];
	logic signed [DW-1:0] cell_data  [CAPACITY];
	logic signed [DW-1:0] or_a;
	logic signed [DW-1:0] or_b;

	logic [CW-1:0]        count_next;
	pls_pkg::status_t     status_next;
	logic signed [DW-1:0] read_next;
	logic [LW-1:0]        len_ext;

	assign pa_ext    = PW'(pa_q);
	assign pb_ext    = PW'(pb_q);
	assign count_ext = PW'(count_q);
	assign pa_m1     = pa_ext - PW'(1);
	assign pb_m1     = pb_ext - PW'(1);
	assign valid_a   = (pa_q != 8'd0) && (pa_ext <= count_ext);
	assign valid_b   = (pb_q != 8'd0) && (pb_ext <= count_ext);
	assign full      = (count_ext >= PW'(CAPACITY));
	assign idx_a     = pa_m1[IW-1:0];
	assign idx_b     = pb_m1[IW-1:0];

	// Insert slot: front for position zero or one, append past the end.
	always_comb begin
		priority if (pa_q <= 8'd1) begin
			slot = '0;
		end else if (pa_ext > count_ext) begin
			slot = count_q[IW-1:0];
		end else begin
			slot = idx_a;
		end
	end

	assign index_a = (action_q == pls_pkg::ACT_INSERT) ? slot : idx_a;

	assign fire = (state_q == S_APPLY) && (!out_valid_q || !out_stall);

	assign cmd.insert = fire && (action_q == pls_pkg::ACT_INSERT) && !full;
	assign cmd.delete = fire && (action_q == pls_pkg::ACT_DELETE) && valid_a;
	assign cmd.swap   = fire && (action_q == pls_pkg::ACT_SWAP) && valid_a && valid_b;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [DW-1:0] left_d;
		logic signed [DW-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		pls_cell #(
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.index_a     (index_a),
			.index_b     (idx_b),
			.value       (value_q),
			.left_data   (left_d),
			.right_data  (right_d),
			.swap_a_data (read_a_q),
			.swap_b_data (read_b_q),
			.sel_a_data  (cell_sel_a[i]),
			.sel_b_data  (cell_sel_b[i]),
			.data        (cell_data[i])
		);
	end

	// Only the addressed cell drives a nonzero select output.
	always_comb begin
		or_a = '0;
		or_b = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			or_a = or_a | cell_sel_a[i];
			or_b = or_b | cell_sel_b[i];
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = pls_pkg::ST_OK;
		read_next   = '0;
		unique case (action_q)
			pls_pkg::ACT_INSERT: begin
				if (full) begin
					status_next = pls_pkg::ST_FULL;
				end else begin
					count_next = count_q + CW'(1);
				end
			end
			pls_pkg::ACT_DELETE: begin
				if (!valid_a) begin
					status_next = pls_pkg::ST_RANGE;
				end else begin
					count_next = count_q - CW'(1);
				end
			end
			pls_pkg::ACT_READ: begin
				if (!valid_a) begin
					status_next = pls_pkg::ST_RANGE;
					read_next   = pls_pkg::OUT_OF_RANGE_VALUE;
				end else begin
					read_next = read_a_q;
				end
			end
			pls_pkg::ACT_SWAP: begin
				if (!valid_a || !valid_b) begin
					status_next = pls_pkg::ST_RANGE;
				end
			end
			default: begin
				status_next = pls_pkg::ST_OK;
			end
		endcase
	end

	assign len_ext = LW'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (fire) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			action_q <= action;
			pa_q     <= position_a;
			pb_q     <= position_b;
			value_q  <= value;
		end
		if (state_q == S_FETCH) begin
			read_a_q <= or_a;
			read_b_q <= or_b;
		end
		if (fire) begin
			read_value_q  <= read_next;
			status_q      <= status_next;
			list_length_q <= len_ext[6:0];
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign read_value  = read_value_q;
	assign status      = status_q;
	assign list_length = list_length_q;

endmodule
